@@ rtl/lock_table_deadlock_detect_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lock table block
// Each macro expands to a labelled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef LOCK_TABLE_DEADLOCK_DETECT_ASSERT_SVH
`define LOCK_TABLE_DEADLOCK_DETECT_ASSERT_SVH
`ifndef SYNTHESIS
`define LTDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LTDD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LTDD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LTDD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ltdd_pkg.sv @@
// ----------------------------------------------------------------------------
// ltdd_pkg
// Shared types and constants of the lock table with deadlock detection.
// ----------------------------------------------------------------------------
package ltdd_pkg;
    localparam int NUM_TXN_DEF = 16;
    localparam int NUM_RES_DEF = 64;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ABORT   = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_CLOSE,
        S_CHECK,
        S_SWEEP,
        S_FINAL,
        S_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture request
        logic rd_row;      // read addressed resource row
        logic eval;        // decide conflict, write row
        logic close_step;  // one closure pivot
        logic sweep_init;  // start lock sweep
        logic sweep_step;  // clear txn bit in one row
        logic edges_clr;   // clear row and column of txn
        logic rd_final;    // reread addressed row
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic conflict;
        logic close_done;
        logic cycle;
        logic sweep_done;
        logic do_req;
        logic do_rel;
        logic do_abort;
    } t_sts;
endpackage

@@ rtl/ltdd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ltdd_ctrl
// Sequencer that steps one operation at a time through the datapath.
// ----------------------------------------------------------------------------
module ltdd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ltdd_pkg::t_sts   i_sts,
    output ltdd_pkg::t_cmd   o_cmd
);
    ltdd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltdd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ltdd_pkg::S_IDLE:  if (i_in_valid) n_state = ltdd_pkg::S_READ;
            ltdd_pkg::S_READ: begin
                if (i_sts.do_abort) n_state = ltdd_pkg::S_SWEEP;
                else n_state = ltdd_pkg::S_EVAL;
            end
            ltdd_pkg::S_EVAL: begin
                if (i_sts.do_req && i_sts.conflict) n_state = ltdd_pkg::S_CLOSE;
                else n_state = ltdd_pkg::S_FINAL;
            end
            ltdd_pkg::S_CLOSE: if (i_sts.close_done) n_state = ltdd_pkg::S_CHECK;
            ltdd_pkg::S_CHECK: begin
                if (i_sts.cycle) n_state = ltdd_pkg::S_SWEEP;
                else n_state = ltdd_pkg::S_FINAL;
            end
            ltdd_pkg::S_SWEEP: if (i_sts.sweep_done) n_state = ltdd_pkg::S_FINAL;
            ltdd_pkg::S_FINAL: n_state = ltdd_pkg::S_OUT;
            ltdd_pkg::S_OUT:   if (i_out_ready) n_state = ltdd_pkg::S_IDLE;
            default:           n_state = ltdd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ltdd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ltdd_pkg::S_READ: begin
                o_cmd.rd_row     = 1'b1;
                o_cmd.sweep_init = i_sts.do_abort;
            end
            ltdd_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            ltdd_pkg::S_CLOSE: o_cmd.close_step = 1'b1;
            ltdd_pkg::S_CHECK: begin
                o_cmd.sweep_init = i_sts.cycle;
                o_cmd.edges_clr  = i_sts.cycle;
            end
            ltdd_pkg::S_SWEEP: o_cmd.sweep_step = 1'b1;
            ltdd_pkg::S_FINAL: o_cmd.rd_final = 1'b1;
            ltdd_pkg::S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule

@@ rtl/ltdd_dp.sv @@
// ----------------------------------------------------------------------------
// ltdd_dp
// Lock table memory, wait-for matrix, closure unit and lock sweep.
// ----------------------------------------------------------------------------
module ltdd_dp #(
    parameter int NUM_TXN = ltdd_pkg::NUM_TXN_DEF,
    parameter int NUM_RES = ltdd_pkg::NUM_RES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_operation,
    input  logic [3:0]     i_txn,
    input  logic [5:0]     i_resource,
    input  logic           i_want_exclusive,
    input  ltdd_pkg::t_cmd i_cmd,
    output ltdd_pkg::t_sts o_sts,
    output logic           o_success,
    output logic           o_deadlock_abort,
    output logic           o_holds_lock,
    output logic           o_resource_exclusive
);
    localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int TW = $clog2(NUM_TXN);
    localparam int CW = $clog2(NUM_TXN + 1);
    localparam int SW = $clog2(NUM_RES + 1);

    // Row layout: exclusive holders in the upper half, shared in the lower.
    logic [2*NUM_TXN-1:0] mem [NUM_RES];
    logic [SW-1:0]        r_clr_cnt;
    logic                 r_clr_busy;

    logic [1:0]           r_op;
    logic [3:0]           r_txn;
    logic [5:0]           r_res;
    logic                 r_wx;
    logic [2*NUM_TXN-1:0] r_row;
    logic [NUM_TXN-1:0]   r_wf [NUM_TXN];
    logic [NUM_TXN-1:0]   r_reach [NUM_TXN];
    logic [CW-1:0]        r_k;
    logic [SW-1:0]        r_sw;
    logic                 r_sw_rd;
    logic                 r_success, r_dl;
    logic                 r_holds, r_excl;

    logic                 t_ok, r_ok;
    logic [NUM_TXN-1:0]   tbit, others_x, others_s, confl;
    logic [RW-1:0]        raddr;
    logic                 any_cycle;

    assign t_ok = ({28'd0, r_txn} < 32'(NUM_TXN));
    assign r_ok = ({26'd0, r_res} < 32'(NUM_RES));
    assign raddr = RW'(r_res);
    assign tbit = t_ok ? (NUM_TXN'(1) << r_txn[TW-1:0]) : '0;
    assign others_x = r_row[2*NUM_TXN-1:NUM_TXN] & ~tbit;
    assign others_s = r_row[NUM_TXN-1:0] & ~tbit;
    assign confl = others_x | (r_wx ? others_s : '0);

    always_comb begin
        any_cycle = 1'b0;
        for (int i = 0; i < NUM_TXN; i++) any_cycle = any_cycle | r_reach[i][i];
    end

    // The row read in the previous cycle decides the conflict while evaluating.
    assign o_sts.conflict   = o_sts.do_req && (confl != '0);
    assign o_sts.close_done = (r_k == CW'(NUM_TXN - 1));
    assign o_sts.cycle      = any_cycle;
    assign o_sts.sweep_done = !r_clr_busy && (r_sw == SW'(NUM_RES)) && !r_sw_rd;
    assign o_sts.do_req     = t_ok && r_ok && (r_op == ltdd_pkg::OP_REQUEST);
    assign o_sts.do_rel     = t_ok && r_ok && (r_op == ltdd_pkg::OP_RELEASE);
    assign o_sts.do_abort   = t_ok && (r_op == ltdd_pkg::OP_ABORT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_txn <= i_txn;
            r_res <= i_resource;
            r_wx  <= i_want_exclusive;
        end
    end

    // Memory, clearing pass (one row per cycle), sweep (a read and a write of each row).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
            r_sw       <= SW'(NUM_RES);
            r_sw_rd    <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                mem[RW'(r_clr_cnt)] <= '0;
                if (r_clr_cnt == SW'(NUM_RES - 1)) r_clr_busy <= 1'b0;
                r_clr_cnt <= r_clr_cnt + SW'(1);
            end else if (i_cmd.sweep_init) begin
                r_sw    <= '0;
                r_sw_rd <= 1'b0;
            end else if (i_cmd.sweep_step) begin
                // Alternate a read and a write of each row.
                if (!r_sw_rd && r_sw != SW'(NUM_RES)) begin
                    r_row   <= mem[RW'(r_sw)];
                    r_sw_rd <= 1'b1;
                end else if (r_sw_rd) begin
                    mem[RW'(r_sw)] <= r_row & ~{tbit, tbit};
                    r_sw_rd <= 1'b0;
                    r_sw    <= r_sw + SW'(1);
                end
            end else if (i_cmd.rd_row || i_cmd.rd_final) begin
                if (r_ok) r_row <= mem[raddr];
                else r_row <= '0;
            end else if (i_cmd.eval && r_ok && t_ok) begin
                if (r_op == ltdd_pkg::OP_REQUEST && confl == '0) begin
                    if (r_wx) mem[raddr] <= r_row | {tbit, {NUM_TXN{1'b0}}};
                    else mem[raddr] <= r_row | {{NUM_TXN{1'b0}}, tbit};
                end else if (r_op == ltdd_pkg::OP_RELEASE) begin
                    mem[raddr] <= r_row & ~{tbit, tbit};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TXN; i++) r_wf[i] <= '0;
            r_k        <= '0;
            r_success  <= 1'b0;
            r_dl       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_success <= 1'b0;
                r_dl      <= 1'b0;
            end
            if (i_cmd.eval) begin
                r_k <= '0;
                if (o_sts.conflict) begin
                    for (int i = 0; i < NUM_TXN; i++) begin
                        if (TW'(i) == r_txn[TW-1:0]) begin
                            r_wf[i]    <= r_wf[i] | confl;
                            r_reach[i] <= r_wf[i] | confl;
                        end else begin
                            r_reach[i] <= r_wf[i];
                        end
                    end
                end else if (o_sts.do_req ||
                             (o_sts.do_rel &&
                              (((r_row[2*NUM_TXN-1:NUM_TXN] | r_row[NUM_TXN-1:0]) & tbit)
                               != '0))) begin
                    r_success <= 1'b1;
                    for (int i = 0; i < NUM_TXN; i++)
                        r_wf[i] <= (TW'(i) == r_txn[TW-1:0]) ? '0 : (r_wf[i] & ~tbit);
                end
            end
            if (i_cmd.close_step) begin
                for (int i = 0; i < NUM_TXN; i++)
                    if (r_reach[i][r_k[TW-1:0]])
                        r_reach[i] <= r_reach[i] | r_reach[r_k[TW-1:0]];
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.edges_clr) begin
                r_dl <= 1'b1;
                for (int i = 0; i < NUM_TXN; i++)
                    r_wf[i] <= (TW'(i) == r_txn[TW-1:0]) ? '0 : (r_wf[i] & ~tbit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_final) begin
            if (r_ok) begin
                r_holds <= ((mem[raddr][2*NUM_TXN-1:NUM_TXN] | mem[raddr][NUM_TXN-1:0])
                            & tbit) != '0;
                r_excl  <= mem[raddr][2*NUM_TXN-1:NUM_TXN] != '0;
            end else begin
                r_holds <= 1'b0;
                r_excl  <= 1'b0;
            end
        end
    end

    assign o_success            = r_success;
    assign o_deadlock_abort     = r_dl;
    assign o_holds_lock         = r_holds;
    assign o_resource_exclusive = r_excl;
endmodule

@@ rtl/lock_table_deadlock_detect.sv @@
// ----------------------------------------------------------------------------
// lock_table_deadlock_detect
// Shared/exclusive lock manager with wait-for graph deadlock detection.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Fields
// in       input      i_in_valid/o_in_ready    operation, txn, resource, want_exclusive
// out      output     o_out_valid/i_out_ready  success, deadlock_abort, holds_lock,
//                                              resource_exclusive
//
// Query, release and granted requests read the addressed row, evaluate it and
// reread it before the result is shown; no new request is taken until then.
// A refused request adds one closure pivot per cycle, one per txn, and a check.
// An abort, and a deadlock abort after the check, add a sweep to read and write
// every lock row. After reset a clearing pass zeroes the lock memory;
// input is held off until it ends.
// The result waits in place until taken.
module lock_table_deadlock_detect #(
    parameter int NUM_TXN = ltdd_pkg::NUM_TXN_DEF,
    parameter int NUM_RES = ltdd_pkg::NUM_RES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [3:0] i_txn,
    input  logic [5:0] i_resource,
    input  logic       i_want_exclusive,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_success,
    output logic       o_deadlock_abort,
    output logic       o_holds_lock,
    output logic       o_resource_exclusive
);
`include "lock_table_deadlock_detect_assert.svh"

    ltdd_pkg::t_cmd cmd;
    ltdd_pkg::t_sts sts;
    logic           ready_raw;
    logic           clr_done;

    // Gate acceptance until the memory clearing pass is over.
    logic [1:0] r_boot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot <= '0;
        end else if (sts.sweep_done && r_boot != 2'd3) begin
            r_boot <= r_boot + 2'd1;
        end
    end
    assign clr_done   = (r_boot == 2'd3);
    assign o_in_ready = ready_raw && clr_done;

    ltdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid && clr_done),
        .o_in_ready  (ready_raw),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ltdd_dp #(.NUM_TXN(NUM_TXN), .NUM_RES(NUM_RES)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_operation          (i_operation),
        .i_txn                (i_txn),
        .i_resource           (i_resource),
        .i_want_exclusive     (i_want_exclusive),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .o_success            (o_success),
        .o_deadlock_abort     (o_deadlock_abort),
        .o_holds_lock         (o_holds_lock),
        .o_resource_exclusive (o_resource_exclusive)
    );

    `LTDD_ASSERT_IMP(a_no_both, i_clk, i_rst_n, o_out_valid, !(o_success && o_deadlock_abort))
    `LTDD_ASSERT_IMP(a_rdy_out, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `LTDD_ASSERT_NXT(a_load, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule

@@ bench/lock_table_deadlock_detect_tb.sv @@
// ----------------------------------------------------------------------------
// lock_table_deadlock_detect_tb
// Drives random lock requests, releases, aborts and queries through the lock
// table and compares every result with a behavioural lock manager kept here.
// ----------------------------------------------------------------------------
class lock_scoreboard;
    logic [15:0] shared_q [64];
    logic [15:0] excl_q [64];
    logic [15:0] wait_graph [16];
    logic [3:0]  pending [$];
    int          errors;

    function new();
        foreach (shared_q[r]) begin
            shared_q[r] = '0;
            excl_q[r] = '0;
        end
        foreach (wait_graph[t]) wait_graph[t] = '0;
        errors = 0;
    endfunction

    function void drop_edges(int t);
        wait_graph[t] = '0;
        foreach (wait_graph[i]) wait_graph[i][t] = 1'b0;
    endfunction

    function bit has_cycle();
        logic [15:0] reach [16];
        bit found;
        found = 0;
        foreach (reach[i]) reach[i] = wait_graph[i];
        for (int k = 0; k < 16; k++)
            for (int i = 0; i < 16; i++)
                if (reach[i][k]) reach[i] |= reach[k];
        for (int i = 0; i < 16; i++)
            if (reach[i][i]) found = 1;
        return found;
    endfunction

    function void drop_locks(int t);
        for (int r = 0; r < 64; r++) begin
            shared_q[r][t] = 1'b0;
            excl_q[r][t] = 1'b0;
        end
    endfunction

    // Applies one request to the local copy and queues the expected result.
    function void note_request(logic [1:0] op, logic [3:0] t, logic [5:0] r, logic wx);
        logic [15:0] conflicts;
        logic ok, dl;
        ok = 0;
        dl = 0;
        if (op == ltdd_pkg::OP_REQUEST) begin
            conflicts = (excl_q[r] | (wx ? shared_q[r] : 16'h0)) & ~(16'h1 << t);
            if (conflicts != 0) begin
                wait_graph[t] |= conflicts;
                if (has_cycle()) begin
                    drop_locks(t);
                    drop_edges(t);
                    dl = 1;
                end
            end else begin
                if (wx) excl_q[r][t] = 1'b1;
                else shared_q[r][t] = 1'b1;
                drop_edges(t);
                ok = 1;
            end
        end else if (op == ltdd_pkg::OP_RELEASE) begin
            if (shared_q[r][t] | excl_q[r][t]) begin
                shared_q[r][t] = 1'b0;
                excl_q[r][t] = 1'b0;
                drop_edges(t);
                ok = 1;
            end
        end else if (op == ltdd_pkg::OP_ABORT) begin
            drop_locks(t);
        end
        pending.push_back({ok, dl, shared_q[r][t] | excl_q[r][t], excl_q[r] != 0});
    endfunction

    function void check_result(logic [3:0] got);
        logic [3:0] want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %b", $realtime, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got[3] !== want[3])
            $display("%0t: success expected %b actual %b", $realtime, want[3], got[3]);
        if (got[2] !== want[2])
            $display("%0t: deadlock_abort expected %b actual %b", $realtime, want[2], got[2]);
        if (got[1] !== want[1])
            $display("%0t: holds_lock expected %b actual %b", $realtime, want[1], got[1]);
        if (got[0] !== want[0])
            $display("%0t: resource_exclusive expected %b actual %b", $realtime, want[0],
                     got[0]);
        if (got !== want) errors++;
    endfunction
endclass

module lock_table_deadlock_detect_tb;
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_operation = '0;
    logic [3:0] i_txn = '0;
    logic [5:0] i_resource = '0;
    logic       i_want_exclusive = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_success, o_deadlock_abort, o_holds_lock, o_resource_exclusive;

    lock_scoreboard locks = new();
    int  cycles = 0;
    bit  calm = 0;

    lock_table_deadlock_detect uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if (calm) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Results are checked at the rising edge; stalls are chosen at the falling edge.
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_out_valid && i_out_ready)
            locks.check_result({o_success, o_deadlock_abort, o_holds_lock,
                                o_resource_exclusive});
        if (cycles > 2000000) begin
            $display("lock_table_deadlock_detect verification failed");
            $finish;
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    // Valid drops only for a gap; a request with no gap follows straight on.
    task automatic send_request(logic [1:0] op, logic [3:0] t, logic [5:0] r, logic wx);
        int gap;
        gap = gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_txn <= t;
        i_resource <= r;
        i_want_exclusive <= wx;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        locks.note_request(op, t, r, wx);
    endtask

    task automatic random_request();
        logic [1:0] op;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) op = ltdd_pkg::OP_REQUEST;
        else if (pick < 80) op = ltdd_pkg::OP_RELEASE;
        else if (pick < 88) op = ltdd_pkg::OP_ABORT;
        else op = ltdd_pkg::OP_QUERY;
        // Few transactions on few resources so that conflicts and cycles are common.
        if ($urandom_range(0, 9) < 8)
            send_request(op, 4'($urandom_range(0, 5)), 6'($urandom_range(0, 5)),
                         1'($urandom_range(0, 1)));
        else
            send_request(op, 4'($urandom()), 6'($urandom()), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed part: extremes, shared and exclusive on one resource, conflicts between two txns.
        send_request(ltdd_pkg::OP_QUERY, 4'd0, 6'd0, 1'b0);
        send_request(ltdd_pkg::OP_REQUEST, 4'd15, 6'd63, 1'b1);
        send_request(ltdd_pkg::OP_REQUEST, 4'd15, 6'd63, 1'b0);
        send_request(ltdd_pkg::OP_RELEASE, 4'd15, 6'd63, 1'b0);
        send_request(ltdd_pkg::OP_RELEASE, 4'd15, 6'd63, 1'b0);
        send_request(ltdd_pkg::OP_REQUEST, 4'd1, 6'd1, 1'b0);
        send_request(ltdd_pkg::OP_REQUEST, 4'd2, 6'd1, 1'b0);
        send_request(ltdd_pkg::OP_REQUEST, 4'd1, 6'd1, 1'b1);
        send_request(ltdd_pkg::OP_REQUEST, 4'd1, 6'd2, 1'b1);
        send_request(ltdd_pkg::OP_REQUEST, 4'd2, 6'd2, 1'b1);
        send_request(ltdd_pkg::OP_QUERY, 4'd1, 6'd1, 1'b0);
        send_request(ltdd_pkg::OP_REQUEST, 4'd3, 6'd4, 1'b1);
        send_request(ltdd_pkg::OP_REQUEST, 4'd3, 6'd5, 1'b0);
        send_request(ltdd_pkg::OP_ABORT, 4'd3, 6'd4, 1'b0);
        send_request(ltdd_pkg::OP_QUERY, 4'd3, 6'd5, 1'b1);
        send_request(ltdd_pkg::OP_ABORT, 4'd0, 6'd63, 1'b1);
        calm = 1;
        repeat (150) random_request();
        calm = 0;
        repeat (1700) random_request();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (locks.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (locks.errors == 0)
            $display("lock_table_deadlock_detect verification clean");
        else
            $display("lock_table_deadlock_detect verification failed");
        $finish;
    end
endmodule
